/* design/assert_macros.svh */
// Assertion helpers used by the bound checker file lcr_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Clocked check that is also evaluated in reset; guard it with past reset level.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

/* design/lcr_pkg.sv */
`default_nettype none

package lcr_pkg;

  // Converter word and field widths
  localparam int DATA_BITS  = 24;
  localparam int WEIGHT_W   = DATA_BITS + 1;
  localparam int BCNT_W     = $clog2(DATA_BITS + 1);
  localparam int SCALE_W    = 16;
  localparam int HALF_W     = 8;
  localparam int TMO_W      = 20;
  localparam int INTV_W     = 26;
  localparam int CFG_DATA_W = 26;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TMO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTV  = 2'd3;

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd426;
  localparam logic [HALF_W-1:0]  HALF_RST  = 8'd1;
  localparam logic [TMO_W-1:0]   TMO_RST   = 20'd1000000;
  localparam logic [INTV_W-1:0]  INTV_RST  = 26'd1000000;

  // Divider request: start, magnitude and sign of the tared count, and the scale
  typedef struct packed {
    logic                 start;
    logic                 neg;
    logic [DATA_BITS-1:0] mag;
    logic [SCALE_W-1:0]   divisor;
  } div_req_t;

  // Divider response: one-cycle done and the signed quotient
  typedef struct packed {
    logic                       done;
    logic signed [WEIGHT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

/* design/lcr_div.sv */
`default_nettype none

module lcr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lcr_pkg::div_req_t req,
  output lcr_pkg::div_rsp_t rsp
);
  import lcr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [BCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SCALE_W-1:0]   rem_r, rem_nxt;
  logic [DATA_BITS-1:0] quo_r, quo_nxt;
  logic [SCALE_W-1:0]   dvs_r, dvs_nxt;
  logic                 neg_r, neg_nxt;
  logic [SCALE_W:0]     trial;
  logic [SCALE_W:0]     diff;
  logic                 ge;
  logic [WEIGHT_W-1:0]  quo_ext;

  // One restoring step per cycle: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_r, quo_r[DATA_BITS-1]};
    ge       = (trial >= {1'b0, dvs_r});
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.mag;
      dvs_nxt  = req.divisor;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
      quo_nxt = {quo_r[DATA_BITS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BCNT_W'(DATA_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // Apply the sign to the magnitude quotient (truncates toward zero)
  assign quo_ext  = {1'b0, quo_r};
  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? $signed(-quo_ext) : $signed(quo_ext);

endmodule

`default_nettype wire

/* design/load_cell_adc_reader_with_tare.sv */
// Load cell reader for a two-wire 24-bit serial converter, with automatic tare.
// Input channel: one transaction per timing tick, carrying the sampled data-out
// level (in_dout_level, 0 = converter ready). Output channel: one transaction per
// tick with the clock level to drive for that tick, a weight-valid pulse, the
// latest weight in grams, the latest raw count, tare-done and a sticky timeout.
// Ticks are taken one per cycle unless the output or the divider stalls; each
// result goes to an output register; the next tick is accepted while it is taken.
// The tick that completes a tared conversion starts the restoring divider, which
// retires one quotient bit per cycle; no tick is taken until its quotient has
// reached the output register. Configuration (cfg_we/cfg_index/cfg_wdata) is to
// be written by the user only while the block is idle; it does not enforce this.
// Reset (rst_n low, synchronous) restores the default registers, clears the tare
// and timeout state, and starts the first conversion on the first tick.
// A stall on the output holds the result and its payload and stalls the input.
// A wait that times out after the tare halts reading until the next reset.
`default_nettype none

module load_cell_adc_reader_with_tare (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_dout_level,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_sck_level,
  output logic                                 out_weight_valid,
  output logic signed [lcr_pkg::WEIGHT_W-1:0]  out_net_weight,
  output logic [lcr_pkg::DATA_BITS-1:0]        out_adc_code,
  output logic                                 out_tare_done,
  output logic                                 out_timeout_flag,
  input  logic                                 cfg_we,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import lcr_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_WAIT  = 6'b000010,
    PH_HIGH  = 6'b000100,
    PH_LOW   = 6'b001000,
    PH_EXTRA = 6'b010000,
    PH_HALT  = 6'b100000
  } phase_t;

  // Configuration registers
  logic [SCALE_W-1:0] scale_r;
  logic [HALF_W-1:0]  half_r;
  logic [TMO_W-1:0]   tmo_r;
  logic [INTV_W-1:0]  intv_ticks_r;

  // Conversion state
  phase_t               phase_r, phase_nxt, ph;
  logic [BCNT_W-1:0]    bit_cnt_r, bit_cnt_nxt, bit_inc;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [HALF_W-1:0]    hp_cnt_r, hp_cnt_nxt, half_eff;
  logic [HALF_W:0]      hp_inc;
  logic                 half_hit;
  logic [TMO_W-1:0]     wait_cnt_r, wait_cnt_nxt, wait_base, wait_inc;
  logic [INTV_W-1:0]    intv_cnt_r, intv_cnt_nxt;
  logic [DATA_BITS-1:0] tare_r, tare_nxt;
  logic                 tare_valid_r, tare_valid_nxt;
  logic                 halted_r, halted_nxt;
  logic                 timeout_r, timeout_nxt;
  logic [DATA_BITS-1:0] last_raw_r, last_raw_nxt;
  logic signed [WEIGHT_W-1:0] weight_r;

  // Output and divider handshake
  logic out_valid_r, out_sck_r, out_wv_r;
  logic busy_r;
  logic in_acc, started, sck, fin, div_go;
  logic [DATA_BITS-1:0] raw;
  logic [DATA_BITS:0]   tdiff, tdiff_neg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = busy_r || (out_valid_r && out_stall);
  assign half_eff = (half_r == '0) ? HALF_W'(1) : half_r;
  assign hp_inc   = {1'b0, hp_cnt_r} + 1'b1;
  assign half_hit = (hp_inc >= {1'b0, half_eff});
  assign raw      = shift_r ^ {1'b1, {(DATA_BITS-1){1'b0}}};

  // Advance one tick of the conversion sequencer
  always_comb begin
    intv_cnt_nxt   = intv_cnt_r;
    wait_base      = wait_cnt_r;
    ph             = phase_r;
    started        = (phase_r == PH_IDLE) && !halted_r && (intv_cnt_r == '0);
    if (started) begin
      intv_cnt_nxt = (intv_ticks_r != '0) ? intv_ticks_r - 1'b1 : '0;
      wait_base    = '0;
      ph           = PH_WAIT;
    end else if (intv_cnt_r != '0 && !halted_r) begin
      intv_cnt_nxt = intv_cnt_r - 1'b1;
    end
    wait_inc       = wait_base + 1'b1;
    phase_nxt      = ph;
    wait_cnt_nxt   = wait_base;
    bit_cnt_nxt    = bit_cnt_r;
    bit_inc        = bit_cnt_r + 1'b1;
    shift_nxt      = shift_r;
    hp_cnt_nxt     = hp_cnt_r;
    tare_nxt       = tare_r;
    tare_valid_nxt = tare_valid_r;
    halted_nxt     = halted_r;
    timeout_nxt    = timeout_r;
    last_raw_nxt   = last_raw_r;
    sck            = 1'b0;
    fin            = 1'b0;
    div_go         = 1'b0;
    unique case (ph)
      PH_WAIT: begin
        if (!in_dout_level) begin
          phase_nxt   = PH_HIGH;
          hp_cnt_nxt  = '0;
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
        end else begin
          wait_cnt_nxt = wait_inc;
          if (wait_inc >= tmo_r || wait_inc == '0) begin
            timeout_nxt = 1'b1;
            if (tare_valid_r) begin
              halted_nxt = 1'b1;
              phase_nxt  = PH_HALT;
            end else begin
              phase_nxt  = PH_IDLE;
            end
          end
        end
      end
      PH_HIGH: begin
        sck = 1'b1;
        if (half_hit) begin
          hp_cnt_nxt = '0;
          phase_nxt  = PH_LOW;
        end else begin
          hp_cnt_nxt = hp_inc[HALF_W-1:0];
        end
      end
      PH_LOW: begin
        if (half_hit) begin
          hp_cnt_nxt  = '0;
          shift_nxt   = {shift_r[DATA_BITS-2:0], in_dout_level};
          bit_cnt_nxt = bit_inc;
          phase_nxt   = (bit_inc >= BCNT_W'(DATA_BITS)) ? PH_EXTRA : PH_HIGH;
        end else begin
          hp_cnt_nxt  = hp_inc[HALF_W-1:0];
        end
      end
      PH_EXTRA: begin
        sck = 1'b1;
        if (half_hit) begin
          hp_cnt_nxt = '0;
          fin        = 1'b1;
          phase_nxt  = PH_IDLE;
        end else begin
          hp_cnt_nxt = hp_inc[HALF_W-1:0];
        end
      end
      PH_IDLE, PH_HALT: begin
      end
      default: begin
      end
    endcase
    // Capture the tare on the first good read, else hand off to the divider
    if (fin) begin
      last_raw_nxt = raw;
      if (!tare_valid_r) begin
        tare_nxt       = raw;
        tare_valid_nxt = 1'b1;
      end else begin
        div_go = 1'b1;
      end
    end
  end

  // Tared count as sign and magnitude
  assign tdiff     = {1'b0, raw} - {1'b0, tare_r};
  assign tdiff_neg = -tdiff;

  always_comb begin
    div_req.start   = in_acc && div_go;
    div_req.neg     = tdiff[DATA_BITS];
    div_req.mag     = tdiff[DATA_BITS] ? tdiff_neg[DATA_BITS-1:0] : tdiff[DATA_BITS-1:0];
    div_req.divisor = (scale_r == '0) ? SCALE_W'(1) : scale_r;
  end

  lcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= SCALE_RST;
      half_r       <= HALF_RST;
      tmo_r        <= TMO_RST;
      intv_ticks_r <= INTV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE: scale_r      <= cfg_wdata[SCALE_W-1:0];
        REG_HALF:  half_r       <= cfg_wdata[HALF_W-1:0];
        REG_TMO:   tmo_r        <= cfg_wdata[TMO_W-1:0];
        REG_INTV:  intv_ticks_r <= cfg_wdata[INTV_W-1:0];
      endcase
    end
  end

  // Commit the tick state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      hp_cnt_r     <= '0;
      wait_cnt_r   <= '0;
      intv_cnt_r   <= '0;
      tare_r       <= '0;
      tare_valid_r <= 1'b0;
      halted_r     <= 1'b0;
      timeout_r    <= 1'b0;
      last_raw_r   <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      hp_cnt_r     <= hp_cnt_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      intv_cnt_r   <= intv_cnt_nxt;
      tare_r       <= tare_nxt;
      tare_valid_r <= tare_valid_nxt;
      halted_r     <= halted_nxt;
      timeout_r    <= timeout_nxt;
      last_raw_r   <= last_raw_nxt;
    end
  end

  // Load the output register; hold it back while the divider runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_sck_r   <= 1'b0;
      out_wv_r    <= 1'b0;
      busy_r      <= 1'b0;
      weight_r    <= '0;
    end else begin
      if (in_acc) begin
        out_sck_r   <= sck;
        out_wv_r    <= div_go;
        out_valid_r <= !div_go;
        busy_r      <= div_go;
      end else if (div_rsp.done) begin
        weight_r    <= div_rsp.quot;
        out_valid_r <= 1'b1;
        busy_r      <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sck_level    = out_sck_r;
  assign out_weight_valid = out_wv_r;
  assign out_net_weight   = weight_r;
  assign out_adc_code     = last_raw_r;
  assign out_tare_done    = tare_valid_r;
  assign out_timeout_flag = timeout_r;

endmodule

`default_nettype wire

/* design/lcr_chk.sv */
`default_nettype none
`include "assert_macros.svh"

module lcr_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic                                out_sck_level,
  input wire logic                                out_weight_valid,
  input wire logic signed [lcr_pkg::WEIGHT_W-1:0] out_net_weight,
  input wire logic [lcr_pkg::DATA_BITS-1:0]       out_adc_code,
  input wire logic                                out_tare_done,
  input wire logic                                out_timeout_flag
);

  // A stalled result keeps its payload
  `ASSERT_RST(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_sck_level) && $stable(out_weight_valid) && $stable(out_net_weight) && $stable(out_adc_code))

  // No new tick while a result is stuck in the output register
  `ASSERT_RST(a_in_blocked, out_valid && out_stall |-> in_stall)

  // A weight only comes after the tare, on a clock-high tick
  `ASSERT_RST(a_weight_after_tare, out_valid && out_weight_valid |-> out_tare_done && out_sck_level)

  // Tare and timeout stay set until reset
  `ASSERT_ALWAYS(a_tare_sticky, $past(rst_n) && rst_n && $past(out_tare_done) |-> out_tare_done)
  `ASSERT_ALWAYS(a_tmo_sticky, $past(rst_n) && rst_n && $past(out_timeout_flag) |-> out_timeout_flag)

endmodule

bind load_cell_adc_reader_with_tare lcr_chk u_lcr_chk (.*);

`default_nettype wire

/* test/lcr_result_checker.sv */
// Watches both channels of the load cell reader, predicts every tick result
// and compares the returned transactions field by field.
module lcr_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_dout_level,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_sck_level,
  input  logic                                out_weight_valid,
  input  logic signed [lcr_pkg::WEIGHT_W-1:0] out_net_weight,
  input  logic [lcr_pkg::DATA_BITS-1:0]       out_adc_code,
  input  logic                                out_tare_done,
  input  logic                                out_timeout_flag,
  input  logic                                cfg_we,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                  fail_count,
  output int                                  pending
);
  import lcr_pkg::*;

  localparam logic [DATA_BITS-1:0] SIGN_FLIP  = {1'b1, {(DATA_BITS-1){1'b0}}};
  localparam longint               WEIGHT_MAX = (longint'(1) << DATA_BITS) - 1;

  typedef enum logic [2:0] {
    RD_IDLE, RD_WAIT, RD_HIGH, RD_LOW, RD_EXTRA, RD_HALT
  } reader_phase_t;

  typedef struct packed {
    logic                       sck_level;
    logic                       weight_valid;
    logic signed [WEIGHT_W-1:0] net_weight;
    logic [DATA_BITS-1:0]       adc_code;
    logic                       tare_done;
    logic                       timeout_flag;
  } reader_tick_t;

  // Register copies
  logic [SCALE_W-1:0] scale_cfg;
  logic [HALF_W-1:0]  half_cfg;
  logic [TMO_W-1:0]   tmo_cfg;
  logic [INTV_W-1:0]  intv_cfg;

  // Reader state
  reader_phase_t              ph;
  int                         bit_cnt;
  int                         half_cnt;
  logic [DATA_BITS-1:0]       shift_val;
  logic [TMO_W-1:0]           wait_cnt;
  logic [INTV_W-1:0]          intv_cnt;
  logic [DATA_BITS-1:0]       tare_val;
  logic [DATA_BITS-1:0]       last_raw;
  logic                       tare_ok;
  logic                       halted;
  logic                       tmo_seen;
  logic signed [WEIGHT_W-1:0] weight_reg;

  reader_tick_t predicted_outputs[$];
  int           mismatches = 0;

  assign fail_count = mismatches;

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("ERROR %0t %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Count one half period of the serial clock; zero behaves as one
  function automatic logic half_elapsed();
    int hp;
    hp = (half_cfg == '0) ? 1 : int'(half_cfg);
    half_cnt++;
    if (half_cnt >= hp) begin
      half_cnt = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the reader by one tick and return what the block shows for it
  function automatic reader_tick_t advance_reader(logic dout);
    reader_tick_t         r;
    logic                 started;
    logic [DATA_BITS-1:0] raw;
    longint               diff;
    longint               divisor;
    longint               q;
    r = '0;
    started = 1'b0;

    // Start a conversion once the interval has run out
    if (ph == RD_IDLE && !halted && intv_cnt == '0) begin
      intv_cnt = (intv_cfg == '0) ? '0 : intv_cfg - 1'b1;
      wait_cnt = '0;
      ph = RD_WAIT;
      started = 1'b1;
    end
    if (!started && intv_cnt != '0 && !halted)
      intv_cnt = intv_cnt - 1'b1;

    case (ph)
      RD_WAIT: begin
        if (!dout) begin
          ph = RD_HIGH;
          half_cnt = 0;
          bit_cnt = 0;
          shift_val = '0;
        end else begin
          wait_cnt = wait_cnt + 1'b1;
          if (wait_cnt >= tmo_cfg || wait_cnt == '0) begin
            tmo_seen = 1'b1;
            // Retry a failed tare, halt on any later timeout
            if (tare_ok) begin
              halted = 1'b1;
              ph = RD_HALT;
            end else begin
              ph = RD_IDLE;
            end
          end
        end
      end
      RD_HIGH: begin
        r.sck_level = 1'b1;
        if (half_elapsed()) ph = RD_LOW;
      end
      RD_LOW: begin
        // Sample data-out on the last low tick of each bit
        if (half_elapsed()) begin
          shift_val = {shift_val[DATA_BITS-2:0], dout};
          bit_cnt++;
          ph = (bit_cnt >= DATA_BITS) ? RD_EXTRA : RD_HIGH;
        end
      end
      RD_EXTRA: begin
        r.sck_level = 1'b1;
        if (half_elapsed()) begin
          raw = shift_val ^ SIGN_FLIP;
          last_raw = raw;
          if (!tare_ok) begin
            tare_val = raw;
            tare_ok = 1'b1;
          end else begin
            diff = longint'(raw) - longint'(tare_val);
            divisor = (scale_cfg == '0) ? 1 : longint'(scale_cfg);
            q = diff / divisor;
            if (q > WEIGHT_MAX) q = WEIGHT_MAX;
            if (q < -WEIGHT_MAX) q = -WEIGHT_MAX;
            weight_reg = q[WEIGHT_W-1:0];
            r.weight_valid = 1'b1;
          end
          ph = RD_IDLE;
        end
      end
      default: ;
    endcase

    r.net_weight = weight_reg;
    r.adc_code = last_raw;
    r.tare_done = tare_ok;
    r.timeout_flag = tmo_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    reader_tick_t want;
    if (!rst_n) begin
      // Restore default registers and clear the reader
      scale_cfg = SCALE_RST;
      half_cfg = HALF_RST;
      tmo_cfg = TMO_RST;
      intv_cfg = INTV_RST;
      ph = RD_IDLE;
      bit_cnt = 0;
      half_cnt = 0;
      shift_val = '0;
      wait_cnt = '0;
      intv_cnt = '0;
      tare_val = '0;
      last_raw = '0;
      tare_ok = 1'b0;
      halted = 1'b0;
      tmo_seen = 1'b0;
      weight_reg = '0;
      predicted_outputs.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE: scale_cfg = cfg_wdata[SCALE_W-1:0];
          REG_HALF:  half_cfg = cfg_wdata[HALF_W-1:0];
          REG_TMO:   tmo_cfg = cfg_wdata[TMO_W-1:0];
          REG_INTV:  intv_cfg = cfg_wdata[INTV_W-1:0];
          default: ;
        endcase
      end

      // Predict each accepted tick transaction
      if (in_valid && !in_stall)
        predicted_outputs.push_back(advance_reader(in_dout_level));

      // Compare each accepted result transaction with the oldest prediction
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          flag_mismatch("result with nothing predicted", 1, 0);
        end else begin
          want = predicted_outputs.pop_front();
          if (out_sck_level !== want.sck_level)
            flag_mismatch("sck_level", out_sck_level, want.sck_level);
          if (out_weight_valid !== want.weight_valid)
            flag_mismatch("weight_valid", out_weight_valid, want.weight_valid);
          if (out_net_weight !== want.net_weight)
            flag_mismatch("net_weight", longint'(out_net_weight),
                          longint'(want.net_weight));
          if (out_adc_code !== want.adc_code)
            flag_mismatch("adc_code", out_adc_code, want.adc_code);
          if (out_tare_done !== want.tare_done)
            flag_mismatch("tare_done", out_tare_done, want.tare_done);
          if (out_timeout_flag !== want.timeout_flag)
            flag_mismatch("timeout_flag", out_timeout_flag, want.timeout_flag);
        end
      end
    end
    pending <= predicted_outputs.size();
  end

endmodule

/* test/load_cell_adc_reader_with_tare_tb.sv */
module load_cell_adc_reader_with_tare_tb;
  import lcr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HIGH_RUN_CAP   = 30;
  localparam int SAFE_TMO       = 40;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_dout_level = 1'b1;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_sck_level;
  logic                       out_weight_valid;
  logic signed [WEIGHT_W-1:0] out_net_weight;
  logic [DATA_BITS-1:0]       out_adc_code;
  logic                       out_tare_done;
  logic                       out_timeout_flag;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int high_run = 0;
  int stuck_cycles = 0;

  always #10 clk = ~clk;

  load_cell_adc_reader_with_tare DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_dout_level(in_dout_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sck_level(out_sck_level), .out_weight_valid(out_weight_valid),
    .out_net_weight(out_net_weight), .out_adc_code(out_adc_code),
    .out_tare_done(out_tare_done), .out_timeout_flag(out_timeout_flag),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  lcr_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_dout_level(in_dout_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sck_level(out_sck_level), .out_weight_valid(out_weight_valid),
    .out_net_weight(out_net_weight), .out_adc_code(out_adc_code),
    .out_tare_done(out_tare_done), .out_timeout_flag(out_timeout_flag),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("load_cell_adc_reader_with_tare_tb: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Write all four registers; the block must be idle
  task automatic program_regs(input logic [CFG_DATA_W-1:0] scale,
                              input logic [CFG_DATA_W-1:0] half,
                              input logic [CFG_DATA_W-1:0] tmo,
                              input logic [CFG_DATA_W-1:0] intv);
    cfg_we <= 1'b1;
    cfg_index <= REG_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_index <= REG_HALF;
    cfg_wdata <= half;
    @(posedge clk);
    cfg_index <= REG_TMO;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= REG_INTV;
    cfg_wdata <= intv;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off ticks until every predicted result has come back
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Offer one tick transaction, with random idle cycles ahead of it
  task automatic send_tick(input logic d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dout_level <= d;
    high_run = d ? high_run + 1 : 0;
    do @(posedge clk); while (in_stall);
  endtask

  // Play a converter answering one conversion: ready, then a word MSB first
  task automatic send_word(input logic [DATA_BITS-1:0] word, input int hp);
    send_tick(1'b0);
    for (int b = DATA_BITS - 1; b >= 0; b--) begin
      repeat (hp) send_tick(1'($urandom_range(1)));
      repeat (hp - 1) send_tick(1'($urandom_range(1)));
      send_tick(word[b]);
    end
    repeat (hp) send_tick(1'($urandom_range(1)));
  endtask

  // Random data-out with a changing bias; cap runs of high below the timeout
  task automatic run_ticks(input int n);
    int   p_low;
    logic d;
    p_low = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(3))
          0: p_low = 3;
          1: p_low = 97;
          default: p_low = 50;
        endcase
      end
      d = ($urandom_range(99) >= p_low);
      if (high_run >= HIGH_RUN_CAP) d = 1'b0;
      send_tick(d);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles a little, receiver stalls a lot
    idle_pct = 16;
    stall_pct = 82;

    // Zero settings: immediate timeouts during tare, back-to-back conversions
    program_regs('0, '0, '0, '0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_word(24'h000000, 1);
    send_word(24'h7FFFFF, 1);
    send_word(24'h800000, 1);
    send_word(24'hFFFFFF, 1);
    drain_results(3);

    // Truncation toward zero on both signs, wait shorter than the timeout
    program_regs(7, 2, 5, 0);
    repeat (4) send_tick(1'b1);
    send_word(24'hFFFFF6, 2);
    send_word(24'h00000A, 2);
    drain_results(3);

    program_regs(CFG_DATA_W'($urandom_range(300, 1)), 1, SAFE_TMO, 60);
    run_ticks(250);
    drain_results(3);

    // Sender idles a lot, receiver stalls a little; pause midway to drain
    idle_pct = 82;
    stall_pct = 16;
    program_regs('hFFFF, 3, 'hFFFFF, 200);
    run_ticks(150);
    drain_results(0);
    run_ticks(150);
    drain_results(3);

    // No idling: widest half period, then back to back at full speed
    idle_pct = 0;
    stall_pct = 0;
    program_regs(CFG_DATA_W'($urandom_range(65535)), 'hFF, SAFE_TMO, 1);
    run_ticks(300);
    drain_results(3);
    program_regs(CFG_DATA_W'($urandom_range(65535)), 1, SAFE_TMO, 1);
    run_ticks(250);
    drain_results(3);

    // Timeout after the tare: reading halts for the rest of the run
    program_regs(CFG_DATA_W'($urandom_range(65535, 1)), 1, 2, 'h3FFFFFF);
    repeat (100) send_tick(1'b1);
    repeat (50) send_tick(1'($urandom_range(1)));

    drain_results(40);
    if (fail_count == 0 && pending == 0) begin
      $display("load_cell_adc_reader_with_tare_tb: PASS");
    end else begin
      $display("load_cell_adc_reader_with_tare_tb: FAIL");
    end
    $finish;
  end

endmodule

/* load_cell_adc_reader_with_tare.f */
+incdir+design
design/lcr_pkg.sv
design/lcr_div.sv
design/load_cell_adc_reader_with_tare.sv
design/lcr_chk.sv
test/lcr_result_checker.sv
test/load_cell_adc_reader_with_tare_tb.sv
